>>> sv/tccw_pkg.sv
// text console char writer: shared constants and the response beat type
// no dependencies; compile first
package tccw_pkg;

   localparam int unsigned COLUMNS_DEF = 80;
   localparam int unsigned ROWS_DEF    = 25;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ATTR_W   = 8;
   localparam int unsigned CELL_W   = CHAR_W + ATTR_W;
   localparam int unsigned COL_W    = 7;
   localparam int unsigned ROW_W    = 5;
   localparam int unsigned CURSOR_W = 11;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_COLOR   = 2'd1;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [ATTR_W-1:0] CLEAR_ATTR   = 8'h0F;

   localparam logic [ATTR_W-1:0] DEFAULT_COLOR_RST = 8'h0F;
   localparam logic [ATTR_W-1:0] ERROR_COLOR_RST   = 8'h4F;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_cell;
      logic [CHAR_W-1:0]   cell_char;
      logic [ATTR_W-1:0]   cell_attr;
      logic                error;
   } rsp_beat_type;

endpackage

>>> sv/tccw_ifs.sv
// text console char writer: request, response and csr channel interfaces
// depends on tccw_pkg
interface tccw_req_if import tccw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [CHAR_W-1:0] char_code;
   logic [ATTR_W-1:0] attribute;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             use_cursor;

   modport source (output valid, req_type, char_code, attribute, col, row, use_cursor,
                   input ready);
   modport sink (input valid, req_type, char_code, attribute, col, row, use_cursor,
                 output ready);
endinterface

interface tccw_rsp_if import tccw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_cell;
   logic [CHAR_W-1:0]   cell_char;
   logic [ATTR_W-1:0]   cell_attr;
   logic                error;

   modport source (output valid, cursor_cell, cell_char, cell_attr, error, input ready);
   modport sink (input valid, cursor_cell, cell_char, cell_attr, error, output ready);
endinterface

interface tccw_csr_if import tccw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ATTR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/text_console_char_writer.sv
// channel  dir  beat payload                                       handshake
// req      in   req_type char_code attribute col row use_cursor    valid/ready
// rsp      out  cursor_cell cell_char cell_attr error              valid/ready
// csr      in   index data                                         valid/ready, always ready
//
// put of an ordinary char or newline: answered from idle; read: answered from a read state
// after the registered grid memory read; put that runs off the last row: a read and a write
// per moved cell on the single memory, then zeroing of the last row
// clear: one cell write per cycle
// after reset a clearing pass zeroes the grid; req not taken meanwhile
// the result register holds a stalled beat; a new request is taken once it drains
// depends on tccw_pkg, tccw_ifs, tccw_cell_ram
module text_console_char_writer import tccw_pkg::*; #(
   parameter int unsigned COLUMNS = COLUMNS_DEF,
   parameter int unsigned ROWS    = ROWS_DEF
) (
   input logic   clock,
   input logic   reset,
   tccw_req_if.sink   req,
   tccw_rsp_if.source rsp,
   tccw_csr_if.sink   csr
);

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned IDX_W = $clog2(CELLS);
   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_SCR_RD = 5'b00100,
      ST_SCR_WR = 5'b01000,
      ST_FILL   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [CELL_W-1:0] fill_data_ff, fill_data_in;
   logic              fill_resp_ff, fill_resp_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ATTR_W-1:0] default_color_ff, error_color_ff;
   logic              rsp_valid_ff;
   rsp_beat_type      rsp_beat_ff, rsp_beat_in;
   logic              rsp_load;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   logic              accept;
   logic [ROW_W-1:0]  prow, nrow;
   logic [COL_W-1:0]  pcol, ncol;
   logic              pvalid;
   logic [IDX_W-1:0]  paddr;
   logic [ATTR_W-1:0] put_attr;

   tccw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // addressed position
   always_comb begin
      if (req.use_cursor) begin
         prow   = cur_row_ff;
         pcol   = cur_col_ff;
         pvalid = 1'b1;
      end else begin
         prow   = req.row;
         pcol   = req.col;
         pvalid = (32'(req.col) < COLUMNS) && (32'(req.row) < ROWS);
      end
      paddr    = IDX_W'(32'(prow) * 32'(COLUMNS) + 32'(pcol));
      put_attr = (req.attribute == '0) ? default_color_ff : req.attribute;
      if (req.char_code == CHAR_NEWLINE || 32'(pcol) == COLUMNS - 1) begin
         nrow = prow + 1'b1;
         ncol = '0;
      end else begin
         nrow = prow;
         ncol = pcol + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      fill_data_in = fill_data_ff;
      fill_resp_in = fill_resp_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = fill_data_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      rsp_beat_in  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.req_type)
                  REQ_PUT: begin
                     rsp_load = 1'b1;
                     wr_en    = 1'b1;
                     if (!pvalid) begin
                        wr_addr           = LAST_CELL;
                        wr_data           = {error_color_ff, CHAR_ERROR};
                        rsp_beat_in.error = 1'b1;
                     end else begin
                        wr_en   = (req.char_code != CHAR_NEWLINE);
                        wr_addr = paddr;
                        wr_data = {put_attr, req.char_code};
                        cur_col_in = ncol;
                        if (32'(nrow) == ROWS) begin
                           cur_row_in = ROW_W'(ROWS - 1);
                           rsp_load   = 1'b0;
                           ptr_in     = IDX_W'(COLUMNS);
                           state_in   = ST_SCR_RD;
                        end else begin
                           cur_row_in = nrow;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (pvalid) begin
                        rd_en    = 1'b1;
                        rd_addr  = paddr;
                        state_in = ST_READ;
                     end else begin
                        rsp_load          = 1'b1;
                        rsp_beat_in.error = 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     ptr_in       = '0;
                     fill_data_in = {CLEAR_ATTR, CHAR_BLANK};
                     fill_resp_in = 1'b1;
                     state_in     = ST_FILL;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load              = 1'b1;
            rsp_beat_in.cell_char = rd_data[CHAR_W-1:0];
            rsp_beat_in.cell_attr = rd_data[CELL_W-1:CHAR_W];
            state_in              = ST_IDLE;
         end
         ST_SCR_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - IDX_W'(COLUMNS);
            wr_data = rd_data;
            if (ptr_ff == LAST_CELL) begin
               ptr_in       = IDX_W'(CELLS - COLUMNS);
               fill_data_in = '0;
               fill_resp_in = 1'b1;
               state_in     = ST_FILL;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_SCR_RD;
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               rsp_load = fill_resp_ff;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_beat_in.cursor_cell =
         CURSOR_W'(32'(cur_row_in) * 32'(COLUMNS) + 32'(cur_col_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_FILL;
         ptr_ff           <= '0;
         fill_data_ff     <= '0;
         fill_resp_ff     <= 1'b0;
         cur_row_ff       <= '0;
         cur_col_ff       <= '0;
         default_color_ff <= DEFAULT_COLOR_RST;
         error_color_ff   <= ERROR_COLOR_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_data_ff <= fill_data_in;
         fill_resp_ff <= fill_resp_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr.valid) begin
            unique case (csr.index)
               CSR_DEFAULT_COLOR: default_color_ff <= csr.data;
               CSR_ERROR_COLOR:   error_color_ff   <= csr.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cursor_cell = rsp_beat_ff.cursor_cell;
   assign rsp.cell_char   = rsp_beat_ff.cell_char;
   assign rsp.cell_attr   = rsp_beat_ff.cell_attr;
   assign rsp.error       = rsp_beat_ff.error;

   // an accepted request always leaves a result or work in progress
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || state_ff != ST_IDLE))
      else $error("accepted request produced neither result nor work");

   // cursor stays inside the grid
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) < ROWS) && (32'(cur_col_ff) < COLUMNS))
      else $error("cursor outside the grid");

   // no new result may land while the previous one is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // grid writes stay inside the memory
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < CELLS))
      else $error("grid write outside the memory");

endmodule

>>> sv/tccw_cell_ram.sv
// text console char writer: character grid memory, one write and one read port
// depends on tccw_pkg; read data registered
module tccw_cell_ram import tccw_pkg::*; #(
   parameter int unsigned DEPTH  = COLUMNS_DEF * ROWS_DEF,
   parameter int unsigned ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/tb_text_console_char_writer.sv
// testbench for text_console_char_writer: directed and random console requests,
// each response checked against an in-bench model of the cell grid and cursor
// depends on tccw_pkg, tccw_ifs and the text_console_char_writer rtl
module tb_text_console_char_writer;
   import tccw_pkg::*;

   localparam int unsigned CELLS          = COLUMNS_DEF * ROWS_DEF;
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned ROUNDS         = 5;
   localparam int unsigned ROUND_ITEMS    = 180;
   localparam int unsigned MAX_REPORTS    = 10;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [1:0]        kind;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              at_cursor;
   } console_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tccw_req_if req_if ();
   tccw_rsp_if rsp_if ();
   tccw_csr_if csr_if ();

   text_console_char_writer uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always #10 clock = ~clock;

   // model of the console
   logic [CELL_W-1:0] grid_cells [CELLS];
   int unsigned       cursor_pos;
   logic [ATTR_W-1:0] dflt_color;
   logic [ATTR_W-1:0] err_color;

   rsp_beat_type expected_rsp_q [$];
   int unsigned  fail_count;
   int unsigned  report_count;
   int unsigned  idle_cycles;
   bit           no_idle;
   bit           hold_rsp;

   function automatic rsp_beat_type apply_console_req(input console_req_type r);
      rsp_beat_type      res;
      int unsigned       pos;
      int unsigned       i;
      logic [ATTR_W-1:0] a;
      bit                in_grid;
      res = '0;
      pos = 0;
      if (cursor_pos >= CELLS) cursor_pos = 0;
      if (r.at_cursor) begin
         pos = cursor_pos;
         in_grid = 1'b1;
      end else begin
         in_grid = (r.col < COLUMNS_DEF) && (r.row < ROWS_DEF);
         if (in_grid) pos = r.row * COLUMNS_DEF + r.col;
      end
      case (r.kind)
         REQ_PUT: begin
            a = (r.attr == '0) ? dflt_color : r.attr;
            if (!in_grid) begin
               grid_cells[CELLS-1] = {err_color, CHAR_ERROR};
               res.error = 1'b1;
            end else begin
               if (r.ch == CHAR_NEWLINE) begin
                  pos = (pos / COLUMNS_DEF + 1) * COLUMNS_DEF;
               end else begin
                  grid_cells[pos] = {a, r.ch};
                  pos++;
               end
               if (pos >= CELLS) begin
                  for (i = 0; i + COLUMNS_DEF < CELLS; i++)
                     grid_cells[i] = grid_cells[i + COLUMNS_DEF];
                  for (i = CELLS - COLUMNS_DEF; i < CELLS; i++)
                     grid_cells[i] = '0;
                  pos -= COLUMNS_DEF;
               end
               cursor_pos = pos;
            end
         end
         REQ_READ: begin
            if (!in_grid) begin
               res.error = 1'b1;
            end else begin
               res.cell_char = grid_cells[pos][CHAR_W-1:0];
               res.cell_attr = grid_cells[pos][CELL_W-1:CHAR_W];
            end
         end
         REQ_CLEAR: begin
            for (i = 0; i < CELLS; i++) grid_cells[i] = {CLEAR_ATTR, CHAR_BLANK};
            cursor_pos = 0;
         end
         default: ;
      endcase
      res.cursor_cell = CURSOR_W'(cursor_pos);
      return res;
   endfunction

   function automatic console_req_type mk_req(input logic [1:0] kind, input int unsigned ch,
                                              input int unsigned attr, input int unsigned col,
                                              input int unsigned row, input bit at_cursor);
      console_req_type r;
      r.kind      = kind;
      r.ch        = CHAR_W'(ch);
      r.attr      = ATTR_W'(attr);
      r.col       = COL_W'(col);
      r.row       = ROW_W'(row);
      r.at_cursor = at_cursor;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (no_idle || sel < 60) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic console_req_type random_console_req();
      console_req_type r;
      int unsigned     sel;
      int unsigned     p;
      sel = $urandom_range(0, 99);
      r = mk_req(REQ_PUT, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, COLUMNS_DEF - 1), $urandom_range(0, ROWS_DEF - 1), 1'b0);
      if ($urandom_range(0, 5) == 0) r.attr = '0;
      if (sel < 45) begin
         // typing at the cursor
         r.at_cursor = 1'b1;
         r.col = COL_W'($urandom_range(0, 127));
         r.row = ROW_W'($urandom_range(0, 31));
         if ($urandom_range(0, 9) == 0) r.ch = CHAR_NEWLINE;
      end else if (sel < 65) begin
         if ($urandom_range(0, 3) == 0) r.row = ROW_W'(ROWS_DEF - 1);
         if ($urandom_range(0, 7) == 0) r.col = COL_W'(COLUMNS_DEF - 1);
         if ($urandom_range(0, 11) == 0) r.ch = CHAR_NEWLINE;
      end else if (sel < 70) begin
         r.col = COL_W'($urandom_range(0, 127));
         r.row = ROW_W'($urandom_range(0, 31));
         if ($urandom_range(0, 1) == 0) r.col = COL_W'($urandom_range(COLUMNS_DEF, 127));
         else r.row = ROW_W'($urandom_range(ROWS_DEF, 31));
      end else if (sel < 90) begin
         r.kind = REQ_READ;
         if ($urandom_range(0, 3) == 0) r.at_cursor = 1'b1;
         else if ($urandom_range(0, 7) == 0) begin
            r.col = COL_W'($urandom_range(0, 127));
            r.row = ROW_W'($urandom_range(ROWS_DEF, 31));
         end
      end else if (sel < 92) begin
         r.kind = REQ_CLEAR;
         r.at_cursor = 1'($urandom_range(0, 1));
      end else if (sel < 94) begin
         r.kind = REQ_UNUSED;
         r.col = COL_W'($urandom_range(0, 127));
         r.row = ROW_W'($urandom_range(0, 31));
         r.at_cursor = 1'($urandom_range(0, 1));
      end else begin
         // read back the cell just behind the cursor
         r.kind = REQ_READ;
         p = (cursor_pos == 0) ? 0 : cursor_pos - 1;
         r.col = COL_W'(p % COLUMNS_DEF);
         r.row = ROW_W'(p / COLUMNS_DEF);
      end
      return r;
   endfunction

   task automatic send_req(input console_req_type r);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.req_type   = r.kind;
      req_if.char_code  = r.ch;
      req_if.attribute  = r.attr;
      req_if.col        = r.col;
      req_if.row        = r.row;
      req_if.use_cursor = r.at_cursor;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      expected_rsp_q.push_back(apply_console_req(r));
   endtask

   task automatic stop_req();
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic wait_idle();
      stop_req();
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_if.index = idx;
      csr_if.data  = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_DEFAULT_COLOR) dflt_color = value;
      else if (idx == CSR_ERROR_COLOR) err_color = value;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic test_after_reset();
      send_req(mk_req(REQ_READ, 0, 0, 0, 0, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, COLUMNS_DEF - 1, ROWS_DEF - 1, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, 127, 31, 1'b1));
      wait_idle();
   endtask

   task automatic test_color_registers();
      csr_write(CSR_DEFAULT_COLOR, 8'h00);
      csr_write(CSR_ERROR_COLOR, 8'hFF);
      csr_write(CSR_SPARE_LO, 8'hFF);
      csr_write(CSR_SPARE_HI, 8'h00);
      send_req(mk_req(REQ_PUT, 8'h41, 0, 5, 3, 1'b0));
      send_req(mk_req(REQ_PUT, 8'h42, 8'h12, COLUMNS_DEF, 0, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, 5, 3, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, COLUMNS_DEF - 1, ROWS_DEF - 1, 1'b0));
      wait_idle();
      csr_write(CSR_DEFAULT_COLOR, 8'hFF);
      csr_write(CSR_ERROR_COLOR, 8'h00);
      send_req(mk_req(REQ_PUT, 8'h43, 0, 6, 3, 1'b0));
      send_req(mk_req(REQ_PUT, 8'h44, 0, 0, ROWS_DEF, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, 6, 3, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, COLUMNS_DEF - 1, ROWS_DEF - 1, 1'b0));
      wait_idle();
   endtask

   task automatic test_put_corner_cases();
      send_req(mk_req(REQ_PUT, CHAR_NEWLINE, 8'h33, 0, 0, 1'b1));
      send_req(mk_req(REQ_PUT, 8'h00, 8'h01, 0, 0, 1'b0));
      // last cell written, grid scrolls
      send_req(mk_req(REQ_PUT, 8'hFF, 8'hFF, COLUMNS_DEF - 1, ROWS_DEF - 1, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, COLUMNS_DEF - 1, ROWS_DEF - 2, 1'b0));
      // newline on the last row also scrolls
      send_req(mk_req(REQ_PUT, CHAR_NEWLINE, 8'h80, 0, ROWS_DEF - 1, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, 127, 31, 1'b0));
      send_req(mk_req(REQ_UNUSED, 8'hFF, 8'hFF, 127, 31, 1'b0));
      send_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 1'b0));
      send_req(mk_req(REQ_READ, 0, 0, 0, 0, 1'b1));
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      int unsigned n;
      @(negedge clock);
      hold_rsp = 1'b1;
      for (n = 0; n < 30; n++) send_req(random_console_req());
      while (hold_rsp) @(posedge clock);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int unsigned rnd;
      int unsigned n;
      for (rnd = 0; rnd < ROUNDS; rnd++) begin
         case (rnd)
            0: begin
               csr_write(CSR_DEFAULT_COLOR, DEFAULT_COLOR_RST);
               csr_write(CSR_ERROR_COLOR, ERROR_COLOR_RST);
            end
            1: begin
               csr_write(CSR_DEFAULT_COLOR, 8'h00);
               csr_write(CSR_ERROR_COLOR, 8'h00);
            end
            2: begin
               csr_write(CSR_DEFAULT_COLOR, 8'hFF);
               csr_write(CSR_ERROR_COLOR, 8'hFF);
            end
            default: begin
               csr_write(CSR_DEFAULT_COLOR, ATTR_W'($urandom_range(0, 255)));
               csr_write(CSR_ERROR_COLOR, ATTR_W'($urandom_range(0, 255)));
            end
         endcase
         no_idle = (rnd == 2);
         for (n = 0; n < ROUND_ITEMS; n++) send_req(random_console_req());
         wait_idle();
         no_idle = 1'b0;
      end
   endtask

   // response side: random stalls, plus a long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) begin
               rsp_if.ready = 1'b0;
               repeat (pick_gap()) @(negedge clock);
            end
         end
      end
   end

   // response check
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.cursor_cell, rsp_if.cell_char, rsp_if.cell_attr, rsp_if.error};
         if (expected_rsp_q.size() == 0) begin
            fail_count++;
            if (report_count < MAX_REPORTS)
               $display("unexpected response beat: cursor %0d char %h attr %h err %0d",
                        got.cursor_cell, got.cell_char, got.cell_attr, got.error);
            report_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.cursor_cell !== want.cursor_cell || got.cell_char !== want.cell_char ||
                got.cell_attr !== want.cell_attr || got.error !== want.error) begin
               fail_count++;
               if (report_count < MAX_REPORTS)
                  $display("mismatch: exp %0d %h %h %0d, got %0d %h %h %0d",
                           want.cursor_cell, want.cell_char, want.cell_attr, want.error,
                           got.cursor_cell, got.cell_char, got.cell_attr, got.error);
               report_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned i;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_PUT;
      req_if.char_code  = '0;
      req_if.attribute  = '0;
      req_if.col        = '0;
      req_if.row        = '0;
      req_if.use_cursor = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_DEFAULT_COLOR;
      csr_if.data       = '0;
      fail_count   = 0;
      report_count = 0;
      idle_cycles  = 0;
      no_idle      = 1'b0;
      hold_rsp     = 1'b0;
      for (i = 0; i < CELLS; i++) grid_cells[i] = '0;
      cursor_pos = 0;
      dflt_color = DEFAULT_COLOR_RST;
      err_color  = ERROR_COLOR_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_color_registers();
      test_put_corner_cases();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
